### hw/rtl/mgh_pkg.sv
// Shared types and constants for the masked gray histogram engine.
// No dependencies; imported by the top level, the bin memory and the divider.
package mgh_pkg;

	localparam int unsigned PIX_W  = 8;
	localparam int unsigned Q_BITS = 16;
	localparam int unsigned FRAC_W = Q_BITS + 1;
	localparam logic [FRAC_W-1:0] Q_ONE = FRAC_W'(1) << Q_BITS;
	localparam logic [PIX_W-1:0] MASK_PASS = '1;

	localparam int unsigned PADDR_W = 3;
	localparam logic [0:0] REG_USE_MASK = 1'b0;

	typedef enum logic [1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_ACC   = 2'd1,
		FUNC_READ  = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC_WR,
		ST_RD_DATA,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
	} div_ctrl_t;

endpackage

### hw/rtl/mgh_bin_mem.sv
// Bin count memory: one write port, one registered read port.
// Per-entry valid bits clear all bins at once. Uses mgh_pkg.
module mgh_bin_mem #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = 8,
	parameter int unsigned W     = 20
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clear,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [W-1:0]  wr_data,
	output logic [W-1:0]  rd_data
);
	import mgh_pkg::*;

	logic [W-1:0]     mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [W-1:0]     rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= valid_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hw/rtl/mgh_divider.sv
// Restoring divider, one quotient bit per cycle, NUM_W quotient bits per divide.
// Shared by every bin read. Uses mgh_pkg for the control struct.
module mgh_divider #(
	parameter int unsigned NUM_W = 36,
	parameter int unsigned DEN_W = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mgh_pkg::div_ctrl_t   ctrl_in,
	output logic                 done,
	input  logic [NUM_W-1:0]     num,
	input  logic [DEN_W-1:0]     den,
	output logic [NUM_W-1:0]     quot
);
	import mgh_pkg::*;

	localparam int unsigned CW = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] qs_q;
	logic [DEN_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic             ge;
	logic [DEN_W:0]   diff;

	assign rem_sh = {rem_q, qs_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign diff   = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (ctrl_in.start) begin
			rem_q <= '0;
			qs_q  <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			qs_q  <= {qs_q[NUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl_in.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = qs_q;

endmodule

### hw/rtl/masked_gray_histogram.sv
// Masked gray histogram engine: top level with APB register, sequencer,
// bin memory and shared divider. Uses mgh_pkg, mgh_bin_mem, mgh_divider.
//
// Usage:
//   Input channel (in_valid/in_ready) carries func, pixel, mask_value and
//   bin_select. One item is in work at a time; in_ready is high only while
//   the sequencer is idle.
//   Clear: all bins go to zero via valid bits, and the total goes to zero.
//   Accumulate: memory read, then saturating write; a pixel that is masked
//   out or beyond the bins is neither read nor written.
//   Read: memory read at the transfer, then the sequencer starts the shared
//   divider, which runs COUNT_BITS+17 restoring steps and raises its done
//   flag; the output register then loads the result while the sequencer
//   returns to idle and can take the next transfer.
//   Output channel (out_valid/out_ready) is a register; a stalled result
//   holds the next read at its final step, and clears and accumulates
//   wait behind it.
//   use_mask lies at APB address 0, bit 0. pready is always high.
//   Reset: all bins and the total read as zero, use_mask is 0, no result
//   pending; there is no clearing pass.
module masked_gray_histogram #(
	parameter int unsigned NUM_BINS   = 256,
	parameter int unsigned COUNT_BITS = 20
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mgh_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   func,
	input  logic [mgh_pkg::PIX_W-1:0]    pixel,
	input  logic [mgh_pkg::PIX_W-1:0]    mask_value,
	input  logic [mgh_pkg::PIX_W-1:0]    bin_select,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mgh_pkg::PIX_W-1:0]    bin_number,
	output logic [COUNT_BITS-1:0]        bin_count,
	output logic [mgh_pkg::FRAC_W-1:0]   fraction,
	output logic                         empty_total
);
	import mgh_pkg::*;

	localparam int unsigned AW    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int unsigned NUM_W = COUNT_BITS + Q_BITS + 1;
	localparam logic [PIX_W:0] BINS_LIM = (PIX_W + 1)'(NUM_BINS);

	state_t state_q, state_d;

	logic                  use_mask_q;
	logic [COUNT_BITS-1:0] total_q;
	logic [PIX_W-1:0]      sel_q;
	logic                  sel_ok_q;
	logic [AW-1:0]         acc_addr_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  empty_q;

	logic                  out_valid_q;
	logic [PIX_W-1:0]      bin_number_q;
	logic [COUNT_BITS-1:0] bin_count_q;
	logic [FRAC_W-1:0]     fraction_q;
	logic                  empty_total_q;

	logic                  accept;
	func_t                 func_in;
	logic                  pix_ok;
	logic                  counted;
	logic                  sel_ok;
	logic                  cfg_wr;

	logic                  mem_clear;
	logic                  mem_rd_en;
	logic [AW-1:0]         mem_rd_addr;
	logic                  mem_wr_en;
	logic [COUNT_BITS-1:0] mem_wr_data;
	logic [COUNT_BITS-1:0] mem_rd_data;
	logic [COUNT_BITS-1:0] rd_count;

	div_ctrl_t             div_ctrl;
	logic                  div_done;
	logic [NUM_W-1:0]      div_num;
	logic [NUM_W-1:0]      div_quot;
	logic [FRAC_W-1:0]     frac_val;
	logic                  out_free;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = (paddr[2:2] == REG_USE_MASK) ? {31'b0, use_mask_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_mask_q <= 1'b0;
		end else if (cfg_wr && paddr[2:2] == REG_USE_MASK) begin
			use_mask_q <= pwdata[0];
		end
	end

	assign func_in  = func_t'(func);
	assign accept   = in_valid & in_ready;
	assign pix_ok   = {1'b0, pixel} < BINS_LIM;
	assign counted  = pix_ok & (~use_mask_q | (mask_value == MASK_PASS));
	assign sel_ok   = {1'b0, bin_select} < BINS_LIM;
	assign rd_count = sel_ok_q ? mem_rd_data : '0;
	assign out_free = ~out_valid_q | out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (func_in)
						FUNC_ACC:  state_d = counted ? ST_ACC_WR : ST_IDLE;
						FUNC_READ: state_d = ST_RD_DATA;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_ACC_WR:  state_d = ST_IDLE;
			ST_RD_DATA: state_d = ST_DIV;
			ST_DIV:     state_d = div_done ? ST_OUT : ST_DIV;
			ST_OUT:     state_d = out_free ? ST_IDLE : ST_OUT;
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready       = 1'b0;
		mem_clear      = 1'b0;
		mem_rd_en      = 1'b0;
		mem_rd_addr    = pixel[AW-1:0];
		mem_wr_en      = 1'b0;
		div_ctrl.start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					unique case (func_in)
						FUNC_CLEAR: mem_clear = 1'b1;
						FUNC_ACC: begin
							mem_rd_en   = counted;
							mem_rd_addr = pixel[AW-1:0];
						end
						FUNC_READ: begin
							mem_rd_en   = sel_ok;
							mem_rd_addr = bin_select[AW-1:0];
						end
						default: ;
					endcase
				end
			end
			ST_ACC_WR:  mem_wr_en = 1'b1;
			ST_RD_DATA: div_ctrl.start = 1'b1;
			default: ;
		endcase
	end

	assign mem_wr_data = (&mem_rd_data) ? mem_rd_data : mem_rd_data + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			total_q <= '0;
		end else begin
			state_q <= state_d;
			if (mem_clear) begin
				total_q <= '0;
			end else if (mem_wr_en && !(&total_q)) begin
				total_q <= total_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sel_q      <= bin_select;
			sel_ok_q   <= sel_ok;
			acc_addr_q <= pixel[AW-1:0];
		end
		if (div_ctrl.start) begin
			count_q <= rd_count;
			empty_q <= total_q == '0;
		end
	end

	assign div_num = NUM_W'({rd_count, Q_BITS'(0)}) + NUM_W'(total_q >> 1);

	mgh_bin_mem #(
		.DEPTH (NUM_BINS),
		.AW    (AW),
		.W     (COUNT_BITS)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (mem_clear),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.wr_en   (mem_wr_en),
		.wr_addr (acc_addr_q),
		.wr_data (mem_wr_data),
		.rd_data (mem_rd_data)
	);

	mgh_divider #(
		.NUM_W (NUM_W),
		.DEN_W (COUNT_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl_in (div_ctrl),
		.done    (div_done),
		.num     (div_num),
		.den     (total_q),
		.quot    (div_quot)
	);

	always_comb begin
		if (empty_q) begin
			frac_val = '0;
		end else if (div_quot > NUM_W'(Q_ONE)) begin
			frac_val = Q_ONE;
		end else begin
			frac_val = div_quot[FRAC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			bin_number_q  <= sel_q;
			bin_count_q   <= count_q;
			fraction_q    <= frac_val;
			empty_total_q <= empty_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign bin_number  = bin_number_q;
	assign bin_count   = bin_count_q;
	assign fraction    = fraction_q;
	assign empty_total = empty_total_q;

endmodule
